// ===== hw/rtl/vsag_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// vsag_pkg
// Shared types and constants for the video scanner address generator.
// ---------------------------------------------------------------------------
package vsag_pkg;

  // Item actions.
  typedef enum logic [1:0] {
    ACT_TICK      = 2'd0,
    ACT_SWITCH    = 2'd1,
    ACT_POWER_OFF = 2'd2
  } action_t;

  // Fetch regions.
  localparam logic [1:0] REGION_TEXT  = 2'd0;
  localparam logic [1:0] REGION_ALIAS = 2'd1;
  localparam logic [1:0] REGION_HIRES = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_FRAME_LINES = 1'b0;
  localparam logic CFG_ENHANCED    = 1'b1;

  // Mode bit positions.
  localparam int BIT_TEXT  = 0;
  localparam int BIT_MIXED = 1;
  localparam int BIT_PAGE2 = 2;
  localparam int BIT_HIRES = 3;

  localparam logic [8:0]  FRAME_LINES_RST = 9'd262;
  localparam logic [8:0]  VERT_RST        = 9'h100;
  localparam logic [6:0]  HORIZ_FIRST     = 7'h40;
  localparam logic [6:0]  HORIZ_LAST      = 7'h7f;
  localparam logic [6:0]  HORIZ_BLANK_END = 7'h58;
  localparam logic [8:0]  VERT_LAST       = 9'h1ff;
  localparam logic [3:0]  SWITCH_PAGE     = 4'b1010;
  localparam logic [8:0]  ROW_BIAS        = 9'h068;
  localparam logic [14:0] TEXT_BASE1      = 15'h0400;
  localparam logic [14:0] TEXT_BASE2      = 15'h0800;
  localparam logic [14:0] HIRES_BASE1     = 15'h2000;
  localparam logic [14:0] HIRES_BASE2     = 15'h4000;
  localparam logic [14:0] ALIAS_OFFSET    = 15'h1000;

  typedef struct packed {
    logic [14:0] addr;
    logic [1:0]  region;
  } fetch_t;

endpackage : vsag_pkg
`default_nettype wire

// ===== hw/rtl/vsag_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// vsag_in_if / vsag_out_if
// Valid/ready channels for scanner items and scanner results.
// ---------------------------------------------------------------------------
interface vsag_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [6:0] switch_address;

  modport source (output valid, action, switch_address, input ready);
  modport sink   (input valid, action, switch_address, output ready);
endinterface : vsag_in_if

interface vsag_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] fetch_address;
  logic [1:0]  fetch_region;
  logic [6:0]  horiz_count;
  logic [8:0]  vert_count;
  logic [3:0]  mode_flags;

  modport source (output valid, fetch_address, fetch_region, horiz_count, vert_count,
                  mode_flags, input ready);
  modport sink   (input valid, fetch_address, fetch_region, horiz_count, vert_count,
                  mode_flags, output ready);
endinterface : vsag_out_if
`default_nettype wire

// ===== hw/rtl/vsag_fetch.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// vsag_fetch
// Maps scan counters and display mode to the video memory fetch address.
// ---------------------------------------------------------------------------
module vsag_fetch
  import vsag_pkg::*;
(
  input  wire logic [6:0] horiz,
  input  wire logic [8:0] vert,
  input  wire logic [3:0] mode,
  input  wire logic       enhanced,
  output fetch_t          fetch
);

  logic        mixed;
  logic        hires;
  logic [8:0]  v43;
  logic [8:0]  row_sum;
  logic [14:0] offset;
  logic [14:0] base;

  always_comb begin
    mixed = mode[BIT_MIXED] && (vert[7] && vert[5]);
    hires = mode[BIT_HIRES] && !(mode[BIT_TEXT] || mixed);
    v43   = {1'b0, vert[7:6], 6'd0};
    // Column and upper row bits share one small adder; only bits 6:3 survive.
    row_sum = ROW_BIAS + {3'd0, horiz[5:3], 3'd0} + ((v43 >> 3) | (v43 >> 1));
    offset  = {2'd0, 3'd0, vert[5:3], row_sum[6:3], horiz[2:0]};

    if (hires) begin
      offset[12:10] = vert[2:0];
      base          = mode[BIT_PAGE2] ? HIRES_BASE2 : HIRES_BASE1;
      fetch.region  = REGION_HIRES;
    end else begin
      base = mode[BIT_PAGE2] ? TEXT_BASE2 : TEXT_BASE1;
      if (!enhanced && (horiz < HORIZ_BLANK_END)) begin
        base         = base + ALIAS_OFFSET;
        fetch.region = REGION_ALIAS;
      end else begin
        fetch.region = REGION_TEXT;
      end
    end
    fetch.addr = offset + base;
  end

endmodule : vsag_fetch
`default_nettype wire

// ===== hw/rtl/video_scanner_address_generator.sv =====
`default_nettype none
// Latency: a result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle unless the sink stalls; the counter and mode
// update plus the fetch address decode form a single register-to-register stage.
// The output register lets a new beat enter while the sink takes the last one.
// Reset (synchronous, rst_n low): mode off, counters at 0 and 0x100,
// frame_lines 262, enhanced model off, no result pending.
// ---------------------------------------------------------------------------
// video_scanner_address_generator
// Video scan counters, display soft switches and fetch address generation.
// ---------------------------------------------------------------------------
module video_scanner_address_generator
  import vsag_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [8:0] cfg_wdata,
  vsag_in_if.sink         in_ch,
  vsag_out_if.source      out_ch
);

  logic [8:0]  frame_lines_r;
  logic        enhanced_r;
  logic [3:0]  mode_r, mode_nxt;
  logic [6:0]  horiz_r, horiz_nxt;
  logic [8:0]  vert_r, vert_nxt;
  logic        out_valid_r;
  fetch_t      fetch_r;
  fetch_t      fetch_nxt;
  logic        in_fire;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    mode_nxt  = mode_r;
    horiz_nxt = horiz_r;
    vert_nxt  = vert_r;
    case (in_ch.action)
      ACT_TICK: begin
        if (horiz_r == 7'd0) begin
          horiz_nxt = HORIZ_FIRST;
        end else if (horiz_r == HORIZ_LAST) begin
          horiz_nxt = 7'd0;
          // The reload is 512 minus frame_lines, which is the 9-bit negation.
          vert_nxt  = (vert_r == VERT_LAST) ? (9'd0 - frame_lines_r) : (vert_r + 9'd1);
        end else begin
          horiz_nxt = horiz_r + 7'd1;
        end
      end
      ACT_SWITCH: begin
        if (in_ch.switch_address[6:3] == SWITCH_PAGE) begin
          mode_nxt[in_ch.switch_address[2:1]] = in_ch.switch_address[0];
        end
      end
      ACT_POWER_OFF: begin
        mode_nxt = 4'd0;
      end
      default: begin
      end
    endcase
  end

  vsag_fetch u_fetch (
    .horiz    (horiz_nxt),
    .vert     (vert_nxt),
    .mode     (mode_nxt),
    .enhanced (enhanced_r),
    .fetch    (fetch_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_lines_r <= FRAME_LINES_RST;
      enhanced_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_LINES: frame_lines_r <= cfg_wdata;
        CFG_ENHANCED:    enhanced_r    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 4'd0;
      horiz_r     <= 7'd0;
      vert_r      <= VERT_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        mode_r  <= mode_nxt;
        horiz_r <= horiz_nxt;
        vert_r  <= vert_nxt;
      end
      if (in_ch.ready) begin
        out_valid_r <= in_ch.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fetch_r <= fetch_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.fetch_address = fetch_r.addr;
  assign out_ch.fetch_region  = fetch_r.region;
  assign out_ch.horiz_count   = horiz_r;
  assign out_ch.vert_count    = vert_r;
  assign out_ch.mode_flags    = mode_r;

  // An accepted beat always shows up as a pending result in the next cycle.
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_ch.valid)
    else $error("accepted beat produced no result");

  // The horizontal counter never lands in the unreachable 1 to 0x3f range.
  a_horiz_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (horiz_r == 7'd0) || horiz_r[6])
    else $error("horizontal counter in unreachable range");

  // A hires fetch requires hires mode with text off.
  a_hires_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.fetch_region == REGION_HIRES))
      |-> (mode_r[BIT_HIRES] && !mode_r[BIT_TEXT]))
    else $error("hires fetch without hires mode");

  // Results hold their counters until the sink takes them.
  a_counters_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> ($stable(horiz_r) && $stable(vert_r)))
    else $error("scan counters moved while a result was stalled");

endmodule : video_scanner_address_generator
`default_nettype wire
